// ===== sv/vln_pkg.sv =====
// Shared types and constants for the 4D vector length and normalise pipeline.
// No dependencies.
package vln_pkg;

    localparam int IN_W   = 32;  // component width
    localparam int SQ_W   = 64;  // one square
    localparam int SUM_W  = 66;  // sum of four squares, padded to even width
    localparam int ROOT_W = 33;  // floor square root of SUM_W bits
    localparam int REM_W  = 36;  // partial remainder of the root recurrence
    localparam int LEN_W  = 34;  // length field
    localparam int EPS_W  = 16;  // epsilon register

    typedef struct packed {
        logic [3:0][IN_W-1:0] mag;
        logic [3:0]           neg;
    } vec_t;

endpackage

// ===== sv/vln_square_sum.sv =====
// Front of the pipeline: magnitudes, squares and the sum of squares.
// Depends on vln_pkg.
module vln_square_sum
    import vln_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3:0][IN_W-1:0]      in_comp,
    input  logic [EPS_W-1:0]          eps,
    output logic                      out_valid,
    output logic [SUM_W-1:0]          out_sum,
    output vec_t                      out_vec
);

    logic                 a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    vec_t                 a_vec_reg, b_vec_reg, c_vec_reg, d_vec_reg;
    vec_t                 a_vec_next;
    logic [3:0][SQ_W-1:0] b_sq_reg;
    logic [1:0][SQ_W:0]   c_pair_reg;
    logic [SUM_W-1:0]     d_sum_reg, d_sum_next, sum_full;
    logic [SUM_W-1:0]     eps_sq;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_vec_next.neg[i] = in_comp[i][IN_W-1];
            a_vec_next.mag[i] = in_comp[i][IN_W-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
        end
    end

    assign eps_sq   = {{(SUM_W-EPS_W){1'b0}}, eps} << FRAC_BITS;
    assign sum_full = {1'b0, c_pair_reg[0]} + {1'b0, c_pair_reg[1]};
    // a tiny squared length forces the root to zero
    assign d_sum_next = (sum_full <= eps_sq) ? '0 : sum_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_vec_reg <= a_vec_next;
            b_vec_reg <= a_vec_reg;
            c_vec_reg <= b_vec_reg;
            d_vec_reg <= c_vec_reg;
            for (int i = 0; i < 4; i++) begin
                b_sq_reg[i] <= SQ_W'(a_vec_reg.mag[i] * a_vec_reg.mag[i]);
            end
            c_pair_reg[0] <= {1'b0, b_sq_reg[0]} + {1'b0, b_sq_reg[1]};
            c_pair_reg[1] <= {1'b0, b_sq_reg[2]} + {1'b0, b_sq_reg[3]};
            d_sum_reg     <= d_sum_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_sum   = d_sum_reg;
    assign out_vec   = d_vec_reg;

endmodule

// ===== sv/vln_sqrt_stage.sv =====
// One digit of the pipelined floor square root: one result bit per stage.
// Depends on vln_pkg.
module vln_sqrt_stage
    import vln_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_n,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [ROOT_W-1:0] in_root,
    input  vec_t              in_vec,
    output logic              out_valid,
    output logic [SUM_W-1:0]  out_n,
    output logic [REM_W-1:0]  out_rem,
    output logic [ROOT_W-1:0] out_root,
    output vec_t              out_vec
);

    logic              valid_reg;
    logic [SUM_W-1:0]  n_reg;
    logic [REM_W-1:0]  rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    vec_t              vec_reg;
    logic              take;

    // bring down the next two bits, try (root << 2) | 1
    assign rem_sh    = {in_rem[REM_W-3:0], in_n[2*BIT+1 -: 2]};
    assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, in_root, 2'b01};
    assign take      = (rem_sh >= trial);
    assign rem_next  = take ? (rem_sh - trial) : rem_sh;
    assign root_next = {in_root[ROOT_W-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= in_n;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            vec_reg  <= in_vec;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== sv/vln_div_stage.sv =====
// One quotient bit of the four restoring dividers, all lanes side by side.
// Depends on vln_pkg.
module vln_div_stage
    import vln_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int K         = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ROOT_W-1:0]                   in_len,
    input  logic                                in_degen,
    input  logic [3:0]                          in_neg,
    input  logic [3:0][IN_W+FRAC_BITS-1:0]      in_rem,
    input  logic [3:0][FRAC_BITS:0]             in_quo,
    output logic                                out_valid,
    output logic [ROOT_W-1:0]                   out_len,
    output logic                                out_degen,
    output logic [3:0]                          out_neg,
    output logic [3:0][IN_W+FRAC_BITS-1:0]      out_rem,
    output logic [3:0][FRAC_BITS:0]             out_quo
);

    localparam int NUM_W = IN_W + FRAC_BITS;

    logic                        valid_reg, degen_reg;
    logic [ROOT_W-1:0]           len_reg;
    logic [3:0]                  neg_reg;
    logic [3:0][NUM_W-1:0]       rem_reg, rem_next;
    logic [3:0][FRAC_BITS:0]     quo_reg, quo_next;
    logic [NUM_W:0]              dsh;

    assign dsh = {{FRAC_BITS{1'b0}}, in_len} << K;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rem_next[i] = in_rem[i];
            quo_next[i] = in_quo[i];
            if ({1'b0, in_rem[i]} >= dsh) begin
                rem_next[i]    = NUM_W'({1'b0, in_rem[i]} - dsh);
                quo_next[i][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg   <= in_len;
            degen_reg <= in_degen;
            neg_reg   <= in_neg;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_degen = degen_reg;
    assign out_neg   = neg_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

// ===== sv/vec4_length_normalize.sv =====
// Top level: length and unit vector of a signed fixed-point 4D vector.
// Depends on vln_pkg, vln_square_sum, vln_sqrt_stage, vln_div_stage.
//
//  channel   dir  contents
//  s_axis    in   tdata = comp_x, comp_y, comp_z, comp_w
//  m_axis    out  tdata = vec_length, unit_x..unit_w; tuser = degenerate
//  cfg       in   cfg_wr_en / cfg_wr_data = epsilon
//
// One beat in per cycle while the pipeline is not held; the stages are
// squares and sum, one root bit per stage, one quotient bit per stage and
// the output register. The whole pipeline advances together and holds while
// the output register is full and m_axis_tready is low.
// Reset clears every valid bit and sets epsilon to 7.
module vec4_length_normalize
    import vln_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vec_length, unit_x, unit_y, unit_z, unit_w, zero pad
    output logic [((LEN_W+4*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // degenerate
    input  logic        cfg_wr_en,
    input  logic [EPS_W-1:0] cfg_wr_data
);

    localparam int NUM_W  = IN_W + FRAC_BITS;
    localparam int UNIT_W = FRAC_BITS + 2;
    localparam int DATA_W = ((LEN_W + 4*UNIT_W + 7) / 8) * 8;

    logic             en;
    logic [EPS_W-1:0] eps_reg;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(7);
        end else if (cfg_wr_en) begin
            eps_reg <= cfg_wr_data;
        end
    end

    logic [3:0][IN_W-1:0] comp;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            comp[i] = s_axis_tdata[i*IN_W +: IN_W];
        end
    end

    logic              r_valid [0:ROOT_W];
    logic [SUM_W-1:0]  r_n     [0:ROOT_W];
    logic [REM_W-1:0]  r_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] r_root  [0:ROOT_W];
    vec_t              r_vec   [0:ROOT_W];

    vln_square_sum #(.FRAC_BITS(FRAC_BITS)) u_square_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_comp   (comp),
        .eps       (eps_reg),
        .out_valid (r_valid[0]),
        .out_sum   (r_n[0]),
        .out_vec   (r_vec[0])
    );

    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        vln_sqrt_stage #(.BIT(ROOT_W-1-j)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (r_valid[j]),
            .in_n      (r_n[j]),
            .in_rem    (r_rem[j]),
            .in_root   (r_root[j]),
            .in_vec    (r_vec[j]),
            .out_valid (r_valid[j+1]),
            .out_n     (r_n[j+1]),
            .out_rem   (r_rem[j+1]),
            .out_root  (r_root[j+1]),
            .out_vec   (r_vec[j+1])
        );
    end

    logic                      d_valid [0:FRAC_BITS+1];
    logic [ROOT_W-1:0]         d_len   [0:FRAC_BITS+1];
    logic                      d_degen [0:FRAC_BITS+1];
    logic [3:0]                d_neg   [0:FRAC_BITS+1];
    logic [3:0][NUM_W-1:0]     d_rem   [0:FRAC_BITS+1];
    logic [3:0][FRAC_BITS:0]   d_quo   [0:FRAC_BITS+1];

    assign d_valid[0] = r_valid[ROOT_W];
    assign d_len[0]   = r_root[ROOT_W];
    assign d_degen[0] = (r_root[ROOT_W] <= {{(ROOT_W-EPS_W){1'b0}}, eps_reg});
    assign d_neg[0]   = r_vec[ROOT_W].neg;
    assign d_quo[0]   = '0;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d_rem[0][i] = {r_vec[ROOT_W].mag[i], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_div
        vln_div_stage #(.FRAC_BITS(FRAC_BITS), .K(FRAC_BITS-j)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (d_valid[j]),
            .in_len    (d_len[j]),
            .in_degen  (d_degen[j]),
            .in_neg    (d_neg[j]),
            .in_rem    (d_rem[j]),
            .in_quo    (d_quo[j]),
            .out_valid (d_valid[j+1]),
            .out_len   (d_len[j+1]),
            .out_degen (d_degen[j+1]),
            .out_neg   (d_neg[j+1]),
            .out_rem   (d_rem[j+1]),
            .out_quo   (d_quo[j+1])
        );
    end

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_degen_reg;
    logic [UNIT_W-1:0] unit_mag;

    always_comb begin
        m_data_next = '0;
        m_data_next[LEN_W-1:0] = {1'b0, d_len[FRAC_BITS+1]};
        for (int i = 0; i < 4; i++) begin
            unit_mag = {1'b0, d_quo[FRAC_BITS+1][i]};
            if (d_degen[FRAC_BITS+1]) begin
                m_data_next[LEN_W+i*UNIT_W +: UNIT_W] = '0;
            end else if (d_neg[FRAC_BITS+1][i]) begin
                m_data_next[LEN_W+i*UNIT_W +: UNIT_W] = ~unit_mag + 1'b1;
            end else begin
                m_data_next[LEN_W+i*UNIT_W +: UNIT_W] = unit_mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid[FRAC_BITS+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= m_data_next;
            m_degen_reg <= d_degen[FRAC_BITS+1];
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_degen_reg;

endmodule
